@@ rtl/brf_pkg.sv @@
// Shared types and codes for the byte ring FIFO with block read.
package brf_pkg;

    // Operation carried on the input tuser bit
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Kind of a result beat
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_NONE  = 2'd2
    } t_kind;

    // One result beat
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_out;
        logic       last;
        logic       accepted;
        logic [7:0] level;
        logic [7:0] free_space;
    } t_result;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

endpackage

@@ rtl/brf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/brf_ctrl.sv @@
// Pointer, level and block-read sequencing around the byte store.
module brf_ctrl #(
    parameter int DEPTH     = 256,
    parameter int MAX_BLOCK = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input beat
    input  logic                     i_s_valid,
    output logic                     o_s_ready,
    input  logic                     i_opcode,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_packet_end,
    input  logic [6:0]               i_max_len,
    // result queue
    input  logic                     i_q_room,
    output logic                     o_push,
    output brf_pkg::t_result         o_result,
    // byte store
    output logic                     o_we,
    output logic [$clog2(DEPTH)-1:0] o_waddr,
    output logic [7:0]               o_wdata,
    output logic                     o_re,
    output logic [$clog2(DEPTH)-1:0] o_raddr,
    input  logic [7:0]               i_rdata
);
    import brf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(MAX_BLOCK + 1);
    localparam logic [AW-1:0] MAX_LVL = AW'(DEPTH - 1);
    localparam logic [6:0]    MAX_BLK7 = 7'(MAX_BLOCK);

    t_state          r_state, n_state;
    logic [AW-1:0]   r_wp, r_rp, r_level;
    logic [CW-1:0]   r_issue_left, r_push_left;
    logic            r_pend;

    logic            accept, is_write, is_full, is_nothing, push_byte;
    logic [CW-1:0]   max_sat, blk_len;
    logic [AW+6:0]   lvl_ext, max_ext;
    logic [AW-1:0]   lvl_out, free_out;
    logic [AW+7:0]   lvl_wide, free_wide;

    // Decode the incoming beat
    always_comb begin
        accept     = i_s_valid && o_s_ready;
        is_write   = (i_opcode == OP_WRITE);
        is_full    = (r_level == MAX_LVL);
        max_sat    = (i_max_len > MAX_BLK7) ? CW'(MAX_BLOCK) : i_max_len[CW-1:0];
        lvl_ext    = {7'b0, r_level};
        max_ext    = {{AW{1'b0}}, 7'(max_sat)};
        blk_len    = (lvl_ext < max_ext) ? lvl_ext[CW-1:0] : max_sat;
        is_nothing = (r_level == '0) || (max_sat == '0);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !is_write && !is_nothing) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (push_byte && r_push_left == CW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake, store access and result beat
    always_comb begin
        o_s_ready = (r_state == ST_IDLE) && i_q_room;
        push_byte = (r_state == ST_READ) && r_pend && i_q_room;
        o_re      = (r_state == ST_READ) && (r_issue_left != '0) && (!r_pend || push_byte);
        o_raddr   = r_rp;
        o_we      = accept && is_write && !is_full;
        o_waddr   = r_wp;
        o_wdata   = i_data_byte;
        o_push    = (accept && (is_write || is_nothing)) || push_byte;

        o_result  = '0;
        lvl_out   = r_level;
        if (push_byte) begin
            o_result.kind     = KIND_BYTE;
            o_result.data_out = i_rdata;
            o_result.last     = (r_push_left == CW'(1));
            lvl_out           = r_level - AW'(1);
        end else if (is_write) begin
            o_result.kind     = KIND_WRITE;
            o_result.last     = i_packet_end;
            o_result.accepted = !is_full;
            lvl_out           = is_full ? r_level : r_level + AW'(1);
        end else begin
            o_result.kind     = KIND_NONE;
            o_result.last     = 1'b1;
        end
        free_out            = MAX_LVL - lvl_out;
        lvl_wide            = {8'b0, lvl_out};
        free_wide           = {8'b0, free_out};
        o_result.level      = lvl_wide[7:0];
        o_result.free_space = free_wide[7:0];
    end

    // State, pointers and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_wp         <= '0;
            r_rp         <= '0;
            r_level      <= '0;
            r_issue_left <= '0;
            r_push_left  <= '0;
            r_pend       <= 1'b0;
        end else begin
            r_state <= n_state;
            // store a write unless full
            if (o_we) begin
                r_wp    <= (r_wp == MAX_LVL) ? '0 : r_wp + AW'(1);
                r_level <= r_level + AW'(1);
            end
            // arm a block read
            if (accept && !is_write && !is_nothing) begin
                r_issue_left <= blk_len;
                r_push_left  <= blk_len;
            end
            // advance the read address
            if (o_re) begin
                r_rp         <= (r_rp == MAX_LVL) ? '0 : r_rp + AW'(1);
                r_issue_left <= r_issue_left - CW'(1);
            end
            // retire a popped byte
            if (push_byte) begin
                r_push_left <= r_push_left - CW'(1);
                r_level     <= r_level - AW'(1);
            end
            if (o_re) begin
                r_pend <= 1'b1;
            end else if (push_byte) begin
                r_pend <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    logic [AW:0] ptr_diff;
    assign ptr_diff = (r_wp >= r_rp) ? ({1'b0, r_wp} - {1'b0, r_rp})
                                     : ({1'b0, r_wp} + (AW+1)'(DEPTH) - {1'b0, r_rp});

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= MAX_LVL)
        else $error("level above usable capacity");

    a_level_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (ptr_diff == {1'b0, r_level}))
        else $error("level disagrees with pointers");

    a_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> ({1'b0, r_push_left} == {1'b0, r_issue_left} + (CW+1)'(r_pend)))
        else $error("issued and retired byte counts out of step");

    a_no_write_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_state == ST_IDLE) && !o_re)
        else $error("store write overlaps a block read");
`endif

endmodule

@@ rtl/brf_outq.sv @@
// Two-entry result queue that decouples the controller from the output bus.
module brf_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  brf_pkg::t_result i_data,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output brf_pkg::t_result o_data
);
    import brf_pkg::*;

    t_result    r_q [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    logic       pop;

    assign o_room  = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_q[r_rd];
    assign pop     = o_valid && i_ready;

    // Hold the payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room)
        else $error("push into a full result queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result queue occupancy out of range");

    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("waiting result beat changed");
`endif

endmodule

@@ rtl/byte_ring_fifo_block_read_top.sv @@
// Byte ring FIFO with block read: top level with stream ports.
//
// A write beat (tuser 0) stores one byte unless the FIFO holds DEPTH-1
// bytes, and yields one status beat. A read beat (tuser 1) pops min(max_len,
// MAX_BLOCK, level) bytes, one result beat per byte with tlast on the final
// one, or one nothing-read beat when the FIFO is empty or max_len is zero.
// A write or nothing-read item leaves the controller idle, ready for the
// next beat while the result queue has room. A block read fetches its
// first byte from the single read port of the byte store, whose read data
// is registered, then one byte per cycle while the output does not stall.
// A two-entry result queue lets the next item be taken while earlier
// results still wait. The store is not cleared at reset; only written
// entries are ever read. level and free_space report the low 8 bits.
module byte_ring_fifo_block_read_top #(
    parameter int DEPTH     = 256,
    parameter int MAX_BLOCK = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] data_byte, [14:8] max_len, [15] zero
    input  logic        i_s_tuser,   // [0] opcode
    input  logic        i_s_tlast,   // packet_end
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] data_out, [8] accepted, [16:9] level,
                                     // [24:17] free_space, [31:25] zero
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast    // last
);
    import brf_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic          q_room, push;
    t_result       result, q_data;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;

    brf_ctrl #(
        .DEPTH     (DEPTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (i_s_tvalid),
        .o_s_ready    (o_s_tready),
        .i_opcode     (i_s_tuser),
        .i_data_byte  (i_s_tdata[7:0]),
        .i_packet_end (i_s_tlast),
        .i_max_len    (i_s_tdata[14:8]),
        .i_q_room     (q_room),
        .o_push       (push),
        .o_result     (result),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rdata      (rdata)
    );

    brf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    brf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_room  (q_room),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (q_data)
    );

    // Pack the result beat
    assign o_m_tdata = {7'b0, q_data.free_space, q_data.level, q_data.accepted,
                        q_data.data_out};
    assign o_m_tuser = q_data.kind;
    assign o_m_tlast = q_data.last;

endmodule

@@ sim/brf_result_checker.sv @@
// Result checker for the byte ring FIFO: mirrors the FIFO and compares every result beat.
module brf_result_checker #(
    parameter int DEPTH     = 256,
    parameter int MAX_BLOCK = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] data_byte, [14:8] max_len, [15] zero
    input  logic        i_s_tuser,   // [0] opcode
    input  logic        i_s_tlast,   // packet_end
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [7:0] data_out, [8] accepted, [16:9] level,
                                     // [24:17] free_space, [31:25] zero
    input  logic [1:0]  i_m_tuser,   // [1:0] kind
    input  logic        i_m_tlast,   // last
    output int          o_fail_count,
    output int          o_pending
);
    import brf_pkg::*;

    // Mirror of the FIFO contents and pointers
    logic [7:0] fifo_image [DEPTH];
    int         wr_ptr;
    int         rd_ptr;
    int         fail_count;
    t_result    expected_beats [$];

    // Build one result beat from the current fill state
    function automatic t_result fill_beat(t_kind k, logic [7:0] d, logic l, logic a);
        int      lvl;
        t_result r;
        lvl          = (wr_ptr + DEPTH - rd_ptr) % DEPTH;
        r.kind       = k;
        r.data_out   = d;
        r.last       = l;
        r.accepted   = a;
        r.level      = 8'(lvl);
        r.free_space = 8'(DEPTH - 1 - lvl);
        return r;
    endfunction

    // Advance the mirror by one input beat and queue the results it causes
    task automatic predict_fifo_item(logic op, logic [7:0] din, logic pend, logic [6:0] mlen_in);
        int         mlen;
        int         lvl;
        int         n;
        int         nxt;
        logic       acc;
        logic [7:0] b;
        if (op == OP_WRITE) begin
            nxt = (wr_ptr + 1) % DEPTH;
            acc = 1'b0;
            if (nxt != rd_ptr) begin
                fifo_image[wr_ptr] = din;
                wr_ptr             = nxt;
                acc                = 1'b1;
            end
            expected_beats.push_back(fill_beat(KIND_WRITE, 8'd0, pend, acc));
        end else begin
            mlen = (int'(mlen_in) > MAX_BLOCK) ? MAX_BLOCK : int'(mlen_in);
            lvl  = (wr_ptr + DEPTH - rd_ptr) % DEPTH;
            if (lvl == 0 || mlen == 0) begin
                expected_beats.push_back(fill_beat(KIND_NONE, 8'd0, 1'b1, 1'b0));
            end else begin
                n = (lvl < mlen) ? lvl : mlen;
                for (int i = 0; i < n; i++) begin
                    b      = fifo_image[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    expected_beats.push_back(fill_beat(KIND_BYTE, b, (i == n - 1), 1'b0));
                end
            end
        end
    endtask

    // Compare the output beat first, then take in the input beat of the same edge
    always @(posedge i_clk) begin
        t_result exp_beat;
        t_result act_beat;
        if (!i_rst_n) begin
            wr_ptr = 0;
            rd_ptr = 0;
            expected_beats.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                act_beat.kind       = t_kind'(i_m_tuser);
                act_beat.data_out   = i_m_tdata[7:0];
                act_beat.accepted   = i_m_tdata[8];
                act_beat.level      = i_m_tdata[16:9];
                act_beat.free_space = i_m_tdata[24:17];
                act_beat.last       = i_m_tlast;
                if (expected_beats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"unexpected result beat: kind %0d data %02h last %0b",
                                  " acc %0b lvl %0d free %0d"},
                                 act_beat.kind, act_beat.data_out, act_beat.last,
                                 act_beat.accepted, act_beat.level, act_beat.free_space);
                end else begin
                    exp_beat = expected_beats.pop_front();
                    if (exp_beat.kind !== act_beat.kind ||
                        exp_beat.data_out !== act_beat.data_out ||
                        exp_beat.last !== act_beat.last ||
                        exp_beat.accepted !== act_beat.accepted ||
                        exp_beat.level !== act_beat.level ||
                        exp_beat.free_space !== act_beat.free_space) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display({"mismatch exp: kind %0d data %02h last %0b",
                                      " acc %0b lvl %0d free %0d"},
                                     exp_beat.kind, exp_beat.data_out, exp_beat.last,
                                     exp_beat.accepted, exp_beat.level, exp_beat.free_space);
                            $display({"         got: kind %0d data %02h last %0b",
                                      " acc %0b lvl %0d free %0d"},
                                     act_beat.kind, act_beat.data_out, act_beat.last,
                                     act_beat.accepted, act_beat.level, act_beat.free_space);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_fifo_item(i_s_tuser, i_s_tdata[7:0], i_s_tlast, i_s_tdata[14:8]);
        end
        o_pending    <= expected_beats.size();
        o_fail_count <= fail_count;
    end

endmodule

@@ sim/byte_ring_fifo_block_read_top_tb.sv @@
// Testbench top for the byte ring FIFO: clock, reset, beat stimulus and verdict.
module byte_ring_fifo_block_read_top_tb;
    import brf_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int HOLD_LEN   = 300;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending;

    // Idling controls for the sender and receiver processes
    logic        gap_en;
    logic        stall_en;
    logic        hold_req;
    logic        hold_done;

    byte_ring_fifo_block_read_top i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    brf_result_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Drive one input beat, optionally after an idle burst, and hold it until taken
    task automatic send_beat(logic op, logic [7:0] din, logic pend, logic [6:0] mlen);
        if (gap_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= pend;
        s_tdata  <= {1'b0, mlen, din};
        do @(posedge clk); while (!(s_tvalid && s_tready));
        @(negedge clk);
    endtask

    task automatic send_write(logic [7:0] din, logic pend);
        send_beat(OP_WRITE, din, pend, 7'($urandom_range(0, 127)));
    endtask

    task automatic send_read(logic [6:0] mlen);
        send_beat(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), mlen);
    endtask

    // Mixed traffic: writes lean ahead of reads, reads mostly short
    task automatic send_mixed_beat();
        int pick;
        int len_pick;
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
            send_write(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
        end else begin
            len_pick = $urandom_range(0, 9);
            if (len_pick == 0)
                send_read(7'd0);
            else if (len_pick == 1)
                send_read(7'($urandom_range(64, 127)));
            else
                send_read(7'($urandom_range(1, 12)));
        end
    endtask

    // Hold until every queued result has come out
    task automatic wait_drained();
        while (pending != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_done = 1'b1;
            end else if (stall_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_WRITE;
        s_tlast  = 1'b0;
        gap_en   = 1'b1;
        stall_en = 1'b1;
        hold_req = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty reads, byte extremes, zero length, saturating length
        send_read(7'd5);
        send_read(7'd0);
        send_write(8'h00, 1'b0);
        send_write(8'hFF, 1'b1);
        send_write(8'hA5, 1'b0);
        send_write(8'h5A, 1'b1);
        send_read(7'd0);
        send_read(7'd1);
        send_read(7'd127);
        send_read(7'd1);
        send_write(8'h3C, 1'b1);
        send_read(7'd64);
        send_read(7'd65);
        send_write(8'h81, 1'b0);
        send_write(8'h7E, 1'b1);
        send_read(7'd2);
        send_write(8'h01, 1'b0);
        send_read(7'd100);
        s_tvalid <= 1'b0;
        wait_drained();

        // Fill past full while the receiver holds off, so the input stalls
        hold_req = 1'b1;
        for (int i = 0; i < 262; i++)
            send_write(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
        // Drain in full-size blocks, then read once more on empty
        for (int i = 0; i < 4; i++)
            send_read(7'($urandom_range(64, 127)));
        send_read(7'($urandom_range(1, 127)));
        s_tvalid <= 1'b0;
        wait_drained();

        // Mixed random traffic with idling on both sides
        for (int i = 0; i < 90; i++)
            send_mixed_beat();

        // Closing stretch without idling
        gap_en   = 1'b0;
        stall_en = 1'b0;
        for (int i = 0; i < 40; i++)
            send_mixed_beat();
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial begin
        #(CLK_PERIOD * 3000000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ byte_ring_fifo_block_read_top.f @@
rtl/brf_pkg.sv
rtl/brf_ram.sv
rtl/brf_ctrl.sv
rtl/brf_outq.sv
rtl/byte_ring_fifo_block_read_top.sv
sim/brf_result_checker.sv
sim/byte_ring_fifo_block_read_top_tb.sv
